// File: sv/mcpg_pkg.sv
// ----------------------------------------------------------------------------
// mcpg_pkg
// Shared types and constants of the midpoint circle point generator: field
// widths, register indexes and reset values, the controller state type and
// the command, status and point records that pass between the modules.
// ----------------------------------------------------------------------------
package mcpg_pkg;

  // Field widths.
  localparam int RAD_W   = 4;   // radius field
  localparam int STEP_W  = 4;   // octant walk position (0 .. 8)
  localparam int TERM_W  = 9;   // signed decision term
  localparam int PIX_W   = 13;  // signed point coordinate
  localparam int DIM_W   = 12;  // window width and height registers
  localparam int ADDR_W  = 24;  // frame byte address
  localparam int COLOR_W = 24;  // RGB color

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_WIDTH  = 2'd0,
    REG_WINDOW_HEIGHT = 2'd1,
    REG_DRAW_COLOR    = 2'd2
  } reg_index_t;

  localparam logic [DIM_W-1:0]   WIDTH_RESET  = 12'd640;
  localparam logic [DIM_W-1:0]   HEIGHT_RESET = 12'd480;
  localparam logic [COLOR_W-1:0] COLOR_RESET  = 24'hFF0000;

  // Decision term constants.
  localparam logic signed [TERM_W:0] TERM_INIT = 10'sd5;
  localparam logic signed [TERM_W:0] TERM_BIAS = 10'sd4;

  // Controller states.
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // latch a new circle request
    logic emit;  // send the current point and advance the walk
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pt_ready;    // point stage can take a point this cycle
    logic oct_last;    // current point is the eighth of its step
    logic final_step;  // current step is the last of the circle
  } status_t;

  // One outline point before the window and address stage.
  typedef struct packed {
    logic signed [PIX_W-1:0] y;
    logic signed [PIX_W-1:0] x;
    logic                    last;
  } point_t;

  // One result, pixel_x in the lowest bits.
  typedef struct packed {
    logic [COLOR_W-1:0]      pixel_color;
    logic [ADDR_W-1:0]       byte_address;
    logic                    in_window;
    logic signed [PIX_W-1:0] pixel_y;
    logic signed [PIX_W-1:0] pixel_x;
  } result_t;

endpackage

// File: sv/mcpg_ctrl.sv
// ----------------------------------------------------------------------------
// mcpg_ctrl
// Controller of the circle generator. Takes a request while idle, then issues
// one emit command per cycle that the point stage has room, until the eighth
// point of the final step has been sent.
// ----------------------------------------------------------------------------
module mcpg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  mcpg_pkg::status_t status,
  output mcpg_pkg::cmd_t    cmd
);

  mcpg_pkg::state_t state_r;
  mcpg_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mcpg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd.load  = 1'b0;
    cmd.emit  = 1'b0;
    unique case (state_r)
      mcpg_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = mcpg_pkg::ST_RUN;
        end
      end
      mcpg_pkg::ST_RUN: begin
        if (status.pt_ready) begin
          cmd.emit = 1'b1;
          if (status.oct_last && status.final_step) begin
            state_nxt = mcpg_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = mcpg_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/mcpg_dp.sv
// ----------------------------------------------------------------------------
// mcpg_dp
// Walk datapath. Holds the centre, the octant walk position and the decision
// term, forms the eight mirrored points of each step and passes them one at
// a time into the point stage register.
// ----------------------------------------------------------------------------
module mcpg_dp #(
  parameter int MAX_RADIUS = 8,
  parameter int COORD_BITS = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mcpg_pkg::cmd_t              cmd,
  output mcpg_pkg::status_t           status,
  input  logic [COORD_BITS-1:0]       center_x,
  input  logic [COORD_BITS-1:0]       center_y,
  input  logic [mcpg_pkg::RAD_W-1:0]  radius,
  input  logic                        pix_ready,
  output logic                        pt_valid,
  output mcpg_pkg::point_t            pt
);

  localparam int SW = mcpg_pkg::STEP_W;
  localparam int TW = mcpg_pkg::TERM_W;
  localparam int PW = mcpg_pkg::PIX_W;
  localparam logic [mcpg_pkg::RAD_W-1:0] RAD_MAX = mcpg_pkg::RAD_W'(MAX_RADIUS);

  logic [COORD_BITS-1:0] cx_r, cy_r;
  logic [SW-1:0]         x_r, y_r;
  logic signed [TW-1:0]  d_r;
  logic [2:0]            oct_r;
  logic                  pt_valid_r;
  mcpg_pkg::point_t      pt_r;

  logic [mcpg_pkg::RAD_W-1:0] rad_sat;
  logic signed [TW:0]         d_init;
  logic                       term_pos;
  logic signed [SW:0]         nx, ny;
  logic signed [TW:0]         nd;
  logic                       final_step;
  logic [SW-1:0]              ox, oy;
  logic signed [PW-1:0]       cx_e, cy_e, ox_e, oy_e, px, py;

  // Radius saturation and initial decision term 5 - 4r.
  always_comb begin
    rad_sat = (radius > RAD_MAX) ? RAD_MAX : radius;
    d_init  = mcpg_pkg::TERM_INIT - $signed({{(TW - 1 - mcpg_pkg::RAD_W){1'b0}}, rad_sat, 2'b00});
  end

  // Look-ahead to the next step: y steps down on a positive term, then x up.
  always_comb begin
    term_pos = (d_r > 0);
    ny = $signed({1'b0, y_r}) - $signed({{SW{1'b0}}, term_pos});
    nx = $signed({1'b0, x_r}) + $signed((SW + 1)'(1));
    nd = $signed({d_r[TW-1], d_r});
    if (term_pos) begin
      nd = nd - ($signed({{(TW - SW){ny[SW]}}, ny}) <<< 3);
    end
    nd = nd + ($signed({{(TW - SW){nx[SW]}}, nx}) <<< 3) + mcpg_pkg::TERM_BIAS;
    final_step = (nx > ny);
  end

  // Mirrored point of the current octant index.
  always_comb begin
    ox   = oct_r[2] ? y_r : x_r;
    oy   = oct_r[2] ? x_r : y_r;
    cx_e = $signed(PW'(cx_r));
    cy_e = $signed(PW'(cy_r));
    ox_e = $signed(PW'(ox));
    oy_e = $signed(PW'(oy));
    px   = oct_r[0] ? (cx_e - ox_e) : (cx_e + ox_e);
    py   = oct_r[1] ? (cy_e + oy_e) : (cy_e - oy_e);
  end

  // Walk registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      x_r   <= '0;
      y_r   <= '0;
      d_r   <= '0;
      oct_r <= '0;
    end else if (cmd.load) begin
      cx_r  <= center_x;
      cy_r  <= center_y;
      x_r   <= '0;
      y_r   <= SW'(rad_sat);
      d_r   <= d_init[TW-1:0];
      oct_r <= '0;
    end else if (cmd.emit) begin
      oct_r <= oct_r + 3'd1;
      if (&oct_r) begin
        x_r <= nx[SW-1:0];
        y_r <= ny[SW-1:0];
        d_r <= nd[TW-1:0];
      end
    end
  end

  // Point stage valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      pt_valid_r <= 1'b1;
    end else if (pix_ready) begin
      pt_valid_r <= 1'b0;
    end
  end

  // Point stage payload.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pt_r.x    <= px;
      pt_r.y    <= py;
      pt_r.last <= final_step && (&oct_r);
    end
  end

  assign status.pt_ready   = !pt_valid_r || pix_ready;
  assign status.oct_last   = &oct_r;
  assign status.final_step = final_step;
  assign pt_valid          = pt_valid_r;
  assign pt                = pt_r;

endmodule

// File: sv/mcpg_pix.sv
// ----------------------------------------------------------------------------
// mcpg_pix
// Window and address stage. Holds the configuration registers, clips each
// point against the window, forms the frame byte address and keeps the
// result in the output register until it is taken.
// ----------------------------------------------------------------------------
module mcpg_pix (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [mcpg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mcpg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            pt_valid,
  input  mcpg_pkg::point_t                pt,
  output logic                            pix_ready,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic                            out_tlast,
  output mcpg_pkg::result_t               result
);

  localparam int DW = mcpg_pkg::DIM_W;
  localparam int AW = mcpg_pkg::ADDR_W;
  localparam int PW = mcpg_pkg::PIX_W;

  logic [DW-1:0]                 width_r, height_r;
  logic [mcpg_pkg::COLOR_W-1:0]  color_r;
  logic                          out_valid_r;
  logic                          last_r;
  mcpg_pkg::result_t             res_r;

  logic          in_win;
  logic [AW-1:0] prod, sum, addr;

  // Configuration registers; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= mcpg_pkg::WIDTH_RESET;
      height_r <= mcpg_pkg::HEIGHT_RESET;
      color_r  <= mcpg_pkg::COLOR_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mcpg_pkg::REG_WINDOW_WIDTH:  width_r  <= cfg_wdata[DW-1:0];
        mcpg_pkg::REG_WINDOW_HEIGHT: height_r <= cfg_wdata[DW-1:0];
        mcpg_pkg::REG_DRAW_COLOR:    color_r  <= cfg_wdata[mcpg_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Clip and address: 4 * (width * row + column), zero outside the window.
  always_comb begin
    in_win = !pt.x[PW-1] && !pt.y[PW-1] &&
             ($unsigned(pt.x) < {1'b0, width_r}) &&
             ($unsigned(pt.y) < {1'b0, height_r});
    prod = AW'(width_r) * AW'(pt.y[DW-1:0]);
    sum  = prod + AW'($unsigned(pt.x));
    addr = in_win ? {sum[AW-3:0], 2'b00} : '0;
  end

  assign pix_ready = !out_valid_r || out_tready;

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pix_ready) begin
      out_valid_r <= pt_valid;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (pix_ready && pt_valid) begin
      res_r.pixel_x      <= pt.x;
      res_r.pixel_y      <= pt.y;
      res_r.in_window    <= in_win;
      res_r.byte_address <= addr;
      res_r.pixel_color  <= color_r;
      last_r             <= pt.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = last_r;
  assign result     = res_r;

endmodule

// File: sv/midpoint_circle_point_generator_top.sv
// ----------------------------------------------------------------------------
// midpoint_circle_point_generator_top
// Midpoint circle outline generator: one request gives the mirrored outline
// points of a circle, each with clip flag, frame address, color and last.
//
// Channel  Direction  Contents
// in_      slave      tdata: center_x, center_y, radius (low bits first)
// out_     master     tdata: pixel_x, pixel_y, in_window, byte_address,
//                     pixel_color (low bits first); tlast: last point
// cfg_     write      index 0 width, 1 height, 2 draw color
//
// A circle of radius r gives 8 points per walk step, at most 48 points for
// radius 8, sent at one point per cycle while out_tready stays high.
// The walk sequencer emits one point per cycle while the point stage has room; the
// first point reaches the output through the point and output registers, and the next
// request is taken in the cycle after the last point leaves the walk.
// Reset is synchronous: it idles the controller, empties both stages and
// restores the registers to 640, 480 and 0xFF0000.
// A stalled output holds its result; the walk pauses until there is room.
// ----------------------------------------------------------------------------
module midpoint_circle_point_generator_top #(
  parameter int MAX_RADIUS = 8,
  parameter int COORD_BITS = 11
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Fields from bit 0: center_x, center_y, radius.
  input  logic [((2*COORD_BITS+mcpg_pkg::RAD_W+7)/8)*8-1:0] in_tdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // Fields from bit 0: pixel_x, pixel_y, in_window, byte_address, pixel_color.
  output logic [(($bits(mcpg_pkg::result_t)+7)/8)*8-1:0] out_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic                            out_tlast,
  input  logic                            cfg_wr_en,
  input  logic [mcpg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mcpg_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int RW       = mcpg_pkg::RAD_W;
  localparam int RES_W    = $bits(mcpg_pkg::result_t);
  localparam int OUT_PAD  = ((RES_W + 7) / 8) * 8 - RES_W;

  mcpg_pkg::cmd_t    cmd;
  mcpg_pkg::status_t status;
  mcpg_pkg::point_t  pt;
  mcpg_pkg::result_t result;
  logic              pt_valid;
  logic              pix_ready;

  // Controller.
  mcpg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // Walk datapath.
  mcpg_dp #(
    .MAX_RADIUS (MAX_RADIUS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .center_x  (in_tdata[COORD_BITS-1:0]),
    .center_y  (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .radius    (in_tdata[2*COORD_BITS+RW-1:2*COORD_BITS]),
    .pix_ready (pix_ready),
    .pt_valid  (pt_valid),
    .pt        (pt)
  );

  // Window, address and output stage.
  mcpg_pix u_pix (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .pt_valid   (pt_valid),
    .pt         (pt),
    .pix_ready  (pix_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .result     (result)
  );

  // Pack the result with zero fill up to whole bytes.
  assign out_tdata = {{OUT_PAD{1'b0}}, result};

endmodule
